FILE: rtl/core/mts_pkg.sv
// Shared types and codes for the min-tracking stack.
// Holds the input and result item structs, the request codes and the status codes.
// No dependencies.
`default_nettype none

package mts_pkg;

    localparam int ITEM_VALUE_W = 32;
    localparam int DEPTH_FIELD_W = 11;
    localparam int STATUS_W = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic                           req_type;
        logic signed [ITEM_VALUE_W-1:0] push_value;
    } mts_in_item_t;

    typedef struct packed {
        logic signed [ITEM_VALUE_W-1:0] top_value;
        logic signed [ITEM_VALUE_W-1:0] min_value;
        logic [DEPTH_FIELD_W-1:0]       depth;
        logic                           is_empty;
        logic [STATUS_W-1:0]            status;
    } mts_out_item_t;

endpackage : mts_pkg

`default_nettype wire

FILE: rtl/core/min_tracking_stack_top.sv
// Min-tracking stack: push/pop stack that reports its top value and running minimum.
// The result is registered and valid in the cycle after the input is accepted.
// 1 item per cycle unless m_ready stalls, via cached top, second and third entries.
// Deeper entries live in a one-write, one-read memory with registered read data.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result.
// Depends on mts_pkg.
`default_nettype none

module min_tracking_stack_top
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mts_in_item_t  s_item,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mts_out_item_t      m_item
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int ENT_W  = 2 * VALUE_WIDTH;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [VALUE_WIDTH-1:0] top_val_reg, top_val_next;
    logic signed [VALUE_WIDTH-1:0] top_min_reg, top_min_next;
    logic signed [VALUE_WIDTH-1:0] sec_val_reg, sec_min_reg;
    logic signed [VALUE_WIDTH-1:0] below_val_reg, below_min_reg;
    logic                          m_valid_reg;
    mts_out_item_t                 m_item_reg, m_item_next;

    logic [ENT_W-1:0]              mem [STACK_DEPTH];

    logic                          accept;
    logic                          is_full, is_zero;
    logic                          push_ok, pop_ok;
    logic signed [VALUE_WIDTH-1:0] x_val, x_min;
    logic [ADDR_W-1:0]             wr_addr, rd_addr;
    logic [CNT_W-1:0]              wr_idx, rd_idx;
    logic [STATUS_W-1:0]           status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign is_full = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign is_zero = (cnt_reg == '0);
    assign push_ok = accept && (s_item.req_type == OP_PUSH) && !is_full;
    assign pop_ok  = accept && (s_item.req_type == OP_POP) && !is_zero;

    assign x_val   = VALUE_WIDTH'(s_item.push_value);
    assign x_min   = (!is_zero && (top_min_reg <= x_val)) ? top_min_reg : x_val;

    assign wr_idx  = cnt_reg - CNT_W'(2);
    assign rd_idx  = cnt_reg - CNT_W'(4);
    assign wr_addr = wr_idx[ADDR_W-1:0];
    assign rd_addr = rd_idx[ADDR_W-1:0];

    always_comb begin
        cnt_next     = cnt_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        status       = STATUS_DONE;
        if (s_item.req_type == OP_PUSH) begin
            if (is_full) begin
                status = STATUS_PUSH_FULL;
            end else begin
                cnt_next     = cnt_reg + CNT_W'(1);
                top_val_next = x_val;
                top_min_next = x_min;
            end
        end else begin
            if (is_zero) begin
                status = STATUS_POP_EMPTY;
            end else begin
                cnt_next     = cnt_reg - CNT_W'(1);
                top_val_next = sec_val_reg;
                top_min_next = sec_min_reg;
            end
        end
    end

    always_comb begin
        m_item_next.depth    = DEPTH_FIELD_W'(cnt_next);
        m_item_next.is_empty = (cnt_next == '0);
        m_item_next.status   = status;
        if (cnt_next == '0) begin
            m_item_next.top_value = '0;
            m_item_next.min_value = '0;
        end else begin
            m_item_next.top_value = ITEM_VALUE_W'(top_val_next);
            m_item_next.min_value = ITEM_VALUE_W'(top_min_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= m_item_next;
        end
        if (push_ok || pop_ok) begin
            top_val_reg <= top_val_next;
            top_min_reg <= top_min_next;
        end
        if (push_ok) begin
            sec_val_reg   <= top_val_reg;
            sec_min_reg   <= top_min_reg;
            below_val_reg <= sec_val_reg;
            below_min_reg <= sec_min_reg;
        end else if (pop_ok) begin
            sec_val_reg <= below_val_reg;
            sec_min_reg <= below_min_reg;
            // refill the third entry from memory on pop
            {below_val_reg, below_min_reg} <= mem[rd_addr];
        end
    end

    // spill the old second entry into memory on push
    always_ff @(posedge aclk) begin
        if (push_ok && (cnt_reg >= CNT_W'(2))) begin
            mem[wr_addr] <= {sec_val_reg, sec_min_reg};
        end
    end

endmodule : min_tracking_stack_top

`default_nettype wire

FILE: tb/tb_min_tracking_stack_top.sv
// Testbench for min_tracking_stack_top: drives push/pop items and mirrors the stack and its running minimum.
// Each result is checked against the mirror, with random sender bursts and receiver stalls.
// Depends on mts_pkg and min_tracking_stack_top.
`timescale 1ns / 100ps

module tb_min_tracking_stack_top;
    import mts_pkg::*;

    localparam int STACK_LIMIT = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 150;

    class min_stack_mirror;
        int capacity;
        int mismatches;
        logic signed [ITEM_VALUE_W-1:0] value_stack[$];
        logic signed [ITEM_VALUE_W-1:0] floor_stack[$];
        mts_out_item_t pending_views[$];

        function new(int depth_limit);
            capacity = depth_limit;
            mismatches = 0;
        endfunction

        function int held();
            return value_stack.size();
        endfunction

        function int waiting();
            return pending_views.size();
        endfunction

        function void apply_request(mts_in_item_t req);
            mts_out_item_t view;
            logic signed [ITEM_VALUE_W-1:0] run_min;
            view = '0;
            view.status = STATUS_DONE;
            if (req.req_type == OP_PUSH) begin
                if (value_stack.size() >= capacity) begin
                    view.status = STATUS_PUSH_FULL;
                end else begin
                    run_min = req.push_value;
                    if (floor_stack.size() > 0 && floor_stack[$] <= req.push_value) begin
                        run_min = floor_stack[$];
                    end
                    value_stack.push_back(req.push_value);
                    floor_stack.push_back(run_min);
                end
            end else if (value_stack.size() == 0) begin
                view.status = STATUS_POP_EMPTY;
            end else begin
                void'(value_stack.pop_back());
                void'(floor_stack.pop_back());
            end
            view.depth = DEPTH_FIELD_W'(value_stack.size());
            view.is_empty = (value_stack.size() == 0);
            if (value_stack.size() > 0) begin
                view.top_value = value_stack[$];
                view.min_value = floor_stack[$];
            end
            pending_views.push_back(view);
        endfunction

        function void compare_result(mts_out_item_t got);
            mts_out_item_t want;
            logic bad;
            if (pending_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result top=%0d min=%0d depth=%0d empty=%0b status=%0d",
                             $realtime, got.top_value, got.min_value, got.depth,
                             got.is_empty, got.status);
                end
                return;
            end
            want = pending_views.pop_front();
            bad = (got.top_value !== want.top_value) || (got.min_value !== want.min_value)
                || (got.depth !== want.depth) || (got.is_empty !== want.is_empty)
                || (got.status !== want.status);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp top=%0d min=%0d depth=%0d empty=%0b status=%0d",
                             $realtime, want.top_value, want.min_value, want.depth,
                             want.is_empty, want.status);
                    $display("%0t:          got top=%0d min=%0d depth=%0d empty=%0b status=%0d",
                             $realtime, got.top_value, got.min_value, got.depth,
                             got.is_empty, got.status);
                end
            end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    mts_in_item_t  s_item = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    mts_out_item_t m_item;

    min_stack_mirror mirror;
    logic in_fire = 1'b0;
    int   quiet_cycles = 0;
    int   burst_left = 0;
    int   stall_mode = 0;
    int   mode_left = 0;

    min_tracking_stack_top #(
        .STACK_DEPTH(STACK_LIMIT),
        .VALUE_WIDTH(ITEM_VALUE_W)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                mirror.apply_request(s_item);
            end
            if (m_valid && m_ready) begin
                mirror.compare_result(m_item);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 64);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_ready = 1'b1;
            1: m_ready = 1'($urandom_range(0, 1));
            2: m_ready = (mode_left % 4 == 0);
            default: m_ready = (mode_left < 8);
        endcase
    end

    function automatic logic signed [ITEM_VALUE_W-1:0] pick_value(int kind);
        logic signed [ITEM_VALUE_W-1:0] v;
        case (kind)
            0: v = $urandom;
            1: v = ITEM_VALUE_W'($urandom_range(0, 8)) - 32'sd4;
            2: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh8000_0001;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = -32'sd1;
                    default: v = '0;
                endcase
            end
            default: begin
                if (mirror.held() > 0) begin
                    v = mirror.floor_stack[$] - ITEM_VALUE_W'($urandom_range(0, 2));
                end else begin
                    v = $urandom;
                end
            end
        endcase
        return v;
    endfunction

    task automatic issue(input logic op, input logic signed [ITEM_VALUE_W-1:0] value);
        int gap;
        mts_in_item_t req;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        req.req_type = op;
        req.push_value = value;
        s_item = req;
        s_valid = 1'b1;
        do @(negedge aclk); while (!in_fire);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (mirror.waiting() != 0) @(negedge aclk);
    endtask

    initial begin
        int done_items;
        int seg_len;
        int push_pct;
        int seg_kind;
        logic take_pop;
        mirror = new(STACK_LIMIT);
        done_items = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        issue(OP_POP, $urandom);
        issue(OP_PUSH, 32'sh7FFF_FFFF);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sh0000_0000);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PUSH, 32'shAAAA_AAAA);
        repeat (7) issue(OP_POP, $urandom);
        issue(OP_POP, 32'hFFFF_FFFF);
        issue(OP_PUSH, 32'sd1);
        issue(OP_PUSH, 32'sd1);
        issue(OP_PUSH, 32'sd2);
        repeat (4) issue(OP_POP, $urandom);

        drain();

        while (mirror.held() < STACK_LIMIT) issue(OP_PUSH, pick_value($urandom_range(0, 3)));
        repeat (3) issue(OP_PUSH, pick_value($urandom_range(0, 3)));
        issue(OP_POP, $urandom);
        issue(OP_PUSH, pick_value(3));
        issue(OP_PUSH, pick_value(2));

        while (done_items < RANDOM_ITEMS) begin
            seg_len = $urandom_range(4, 60);
            seg_kind = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0: push_pct = 75;
                1: push_pct = 25;
                2: push_pct = 50;
                default: push_pct = 90;
            endcase
            repeat (seg_len) begin
                take_pop = ($urandom_range(0, 99) >= push_pct);
                if (!take_pop || mirror.held() > 0) done_items++;
                if (take_pop) begin
                    issue(OP_POP, $urandom);
                end else if ($urandom_range(0, 4) == 0) begin
                    issue(OP_PUSH, pick_value($urandom_range(0, 3)));
                end else begin
                    issue(OP_PUSH, pick_value(seg_kind));
                end
            end
        end

        drain();
        repeat (4) @(negedge aclk);
        if (mirror.mismatches == 0 && mirror.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
